// ===== rtl/rca_pkg.sv =====
`default_nettype none

package rca_pkg;

  localparam int COEFF_BITS_DEF = 32;
  localparam int DATA_W         = 32;
  localparam int OP_W           = 3;
  localparam int CFG_IDX_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_NEG    = 3'd2,
    OP_SMUL   = 3'd3,
    OP_SIGNAL = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RING_MODULUS  = 2'd0,
    CFG_SCALAR_FACTOR = 2'd1
  } cfg_idx_t;

  localparam logic [DATA_W-1:0] RING_MODULUS_RST  = 32'd3329;
  localparam logic [DATA_W-1:0] SCALAR_FACTOR_RST = 32'd1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] coeff_a;
    logic [DATA_W-1:0] coeff_b;
    logic              last_in;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] coeff_out;
    logic              last_out;
  } out_t;

  // handshake state of the output register pair
  typedef struct packed {
    logic out_full;
    logic skid_full;
  } obuf_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rca_modred.sv =====
`default_nettype none

// Restoring reduction, one input bit per stage: rem = {rem, bit} mod q.
module rca_modred import rca_pkg::*; #(
  parameter int W     = COEFF_BITS_DEF,
  parameter int N     = COEFF_BITS_DEF,
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [N-1:0]  in_val [LANES],
  input  wire logic [W-1:0]  q,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [W-1:0]       out_rem [LANES],
  output logic [SW-1:0]      out_side
);

  logic [W-1:0]  rem  [N][LANES];
  logic [N-1:0]  sh   [N][LANES];
  logic [SW-1:0] side [N];
  logic          vld  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [W-1:0]  rem_prev [LANES];
    logic [N-1:0]  sh_prev  [LANES];
    logic [SW-1:0] side_prev;
    logic          vld_prev;
    logic [W-1:0]  rem_next [LANES];
    logic [N-1:0]  sh_next  [LANES];

    if (k == 0) begin : g_head
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_prev[l] = '0;
          sh_prev[l]  = in_val[l];
        end
        side_prev = in_side;
        vld_prev  = in_valid;
      end
    end else begin : g_body
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_prev[l] = rem[k-1][l];
          sh_prev[l]  = sh[k-1][l];
        end
        side_prev = side[k-1];
        vld_prev  = vld[k-1];
      end
    end

    always_comb begin
      logic [W:0] t;
      t = '0;
      for (int l = 0; l < LANES; l++) begin
        t = {rem_prev[l], sh_prev[l][N-1]};
        // rem_prev < q, so one subtract is enough
        if (t >= {1'b0, q}) begin
          t = t - {1'b0, q};
        end
        rem_next[l] = t[W-1:0];
        sh_next[l]  = sh_prev[l] << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= rem_next;
        sh[k]   <= sh_next;
        side[k] <= side_prev;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_rem   = rem[N-1];
  assign out_side  = side[N-1];

endmodule

`default_nettype wire

// ===== rtl/rca_alu.sv =====
`default_nettype none

// One register stage: add/sub/negate/signal round on reduced operands,
// plus the raw product for scalar multiply.
module rca_alu import rca_pkg::*; #(
  parameter int W = COEFF_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [W-1:0]    a,
  input  wire logic [W-1:0]    b,
  input  wire logic [OP_W-1:0] op,
  input  wire logic            last,
  input  wire logic [W-1:0]    q,
  input  wire logic [W-1:0]    s,
  output logic                 out_valid,
  output logic [2*W-1:0]       prod,
  output logic [W-1:0]         res,
  output logic                 is_mul,
  output logic                 last_q
);

  logic [W-1:0]   res_next;
  logic           is_mul_next;
  logic [W:0]     sum;
  logic [W-1:0]   half, d_zero, d_half, d_half_w, q_minus_a;

  always_comb begin
    sum       = {1'b0, a} + {1'b0, b};
    half      = q >> 1;
    q_minus_a = q - a;
    d_zero    = (a < q_minus_a) ? a : q_minus_a;
    d_half    = (a >= half) ? (a - half) : (half - a);
    d_half_w  = (d_half < (q - d_half)) ? d_half : (q - d_half);
  end

  always_comb begin
    res_next    = '0;
    is_mul_next = 1'b0;
    if (q >= W'(2)) begin
      unique case (op)
        OP_ADD:    res_next = (sum >= {1'b0, q}) ? W'(sum - {1'b0, q}) : sum[W-1:0];
        OP_SUB:    res_next = (a >= b) ? (a - b) : (a + q - b);
        OP_NEG:    res_next = (a == '0) ? '0 : q_minus_a;
        OP_SMUL:   is_mul_next = 1'b1;
        OP_SIGNAL: res_next = (d_zero <= d_half_w) ? '0 : half;
        default:   res_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= a * s;
      res    <= res_next;
      is_mul <= is_mul_next;
      last_q <= last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rca_outbuf.sv =====
`default_nettype none

// Output register with a skid stage; the pipeline runs while the skid is empty.
module rca_outbuf import rca_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  input  wire out_t push_data,
  output logic      en,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data,
  output obuf_stat_t stat
);

  logic ov, sv;
  out_t od, sd;
  logic pop, push;

  assign en   = !sv;
  assign pop  = ov && out_ready;
  assign push = en && push_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else begin
      if (pop) begin
        if (sv) begin
          sv <= 1'b0;
        end else if (!push) begin
          ov <= 1'b0;
        end
      end else if (push) begin
        if (!ov) begin
          ov <= 1'b1;
        end else begin
          sv <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (sv) begin
        od <= sd;
      end else if (push) begin
        od <= push_data;
      end
    end else if (push) begin
      if (!ov) begin
        od <= push_data;
      end else begin
        sd <= push_data;
      end
    end
  end

  assign out_valid      = ov;
  assign out_data       = od;
  assign stat.out_full  = ov;
  assign stat.skid_full = sv;

endmodule

`default_nettype wire

// ===== rtl/ring_coefficient_alu.sv =====
`default_nettype none

// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | in_data (in_t)
// out     | output    | out_valid / out_ready  | out_data (out_t)
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle while the skid stage is empty. Pipeline: COEFF_BITS stages
// reduce both operands one bit each, one stage does the ALU work and the
// multiply, 2*COEFF_BITS stages reduce the product, then the output register.
// Synchronous reset clears the valid bits and loads the register defaults.
// A stalled output fills a skid stage; the whole pipeline then holds.
module ring_coefficient_alu import rca_pkg::*; #(
  parameter int COEFF_BITS = COEFF_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  localparam int W   = COEFF_BITS;
  localparam int SW1 = OP_W + 1;
  localparam int SW2 = W + 2;

  logic [DATA_W-1:0] ring_modulus, scalar_factor;
  logic [W-1:0]      q, s;
  logic              en;
  obuf_stat_t        stat;

  assign cfg_ready = 1'b1;
  assign q         = ring_modulus[W-1:0];
  assign s         = scalar_factor[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_modulus  <= RING_MODULUS_RST;
      scalar_factor <= SCALAR_FACTOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_RING_MODULUS) begin
        ring_modulus <= cfg_data;
      end else if (cfg_index == CFG_SCALAR_FACTOR) begin
        scalar_factor <= cfg_data;
      end
    end
  end

  assign in_ready = en;

  // operand reduction
  logic [W-1:0]   opnd_in  [2];
  logic [W-1:0]   opnd_red [2];
  logic [SW1-1:0] side1_out;
  logic           red_valid;

  assign opnd_in[0] = in_data.coeff_a[W-1:0];
  assign opnd_in[1] = in_data.coeff_b[W-1:0];

  rca_modred #(.W(W), .N(W), .LANES(2), .SW(SW1)) u_opnd_red (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_val   (opnd_in),
    .q        (q),
    .in_side  ({in_data.op, in_data.last_in}),
    .out_valid(red_valid),
    .out_rem  (opnd_red),
    .out_side (side1_out)
  );

  logic           alu_valid, alu_mul, alu_last;
  logic [2*W-1:0] alu_prod;
  logic [W-1:0]   alu_res;

  rca_alu #(.W(W)) u_alu (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (red_valid),
    .a        (opnd_red[0]),
    .b        (opnd_red[1]),
    .op       (side1_out[SW1-1:1]),
    .last     (side1_out[0]),
    .q        (q),
    .s        (s),
    .out_valid(alu_valid),
    .prod     (alu_prod),
    .res      (alu_res),
    .is_mul   (alu_mul),
    .last_q   (alu_last)
  );

  // product reduction
  logic [2*W-1:0] prod_in  [1];
  logic [W-1:0]   prod_red [1];
  logic [SW2-1:0] side2_out;
  logic           fin_valid;
  out_t           fin_data;

  assign prod_in[0] = alu_prod;

  rca_modred #(.W(W), .N(2*W), .LANES(1), .SW(SW2)) u_prod_red (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (alu_valid),
    .in_val   (prod_in),
    .q        (q),
    .in_side  ({alu_res, alu_mul, alu_last}),
    .out_valid(fin_valid),
    .out_rem  (prod_red),
    .out_side (side2_out)
  );

  assign fin_data.coeff_out = DATA_W'(side2_out[1] ? prod_red[0] : side2_out[SW2-1:2]);
  assign fin_data.last_out  = side2_out[0];

  rca_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fin_valid),
    .push_data (fin_data),
    .en        (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (stat)
  );

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    stat.skid_full |-> stat.out_full)
    else $error("skid holds a result while output register is empty");

  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    stat.skid_full && !out_ready |=> !in_ready)
    else $error("input accepted while both output stages are full");

  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid && (q >= W'(2)) |-> (out_data.coeff_out < DATA_W'(q)))
    else $error("result not reduced below modulus");

endmodule

`default_nettype wire
